// ===== hw/rtl/tsfm_pkg.sv =====
// Package for the truncating single-precision multiplier.
// Constants and the per-stage payload types; no dependencies.
`default_nettype none
package tsfm_pkg;
    localparam int unsigned HiW  = 13;
    localparam int unsigned LoW  = 11;
    localparam int unsigned PpW  = 26;
    localparam logic [9:0] ExpBias = 10'd127;

    typedef struct packed {
        logic            zero;
        logic            sign;
        logic [8:0]      esum;
        logic [HiW-1:0]  ha;
        logic [HiW-1:0]  hb;
        logic [LoW-1:0]  la;
        logic [LoW-1:0]  lb;
    } split_t;

    typedef struct packed {
        logic            zero;
        logic            sign;
        logic [8:0]      esum;
        logic [PpW-1:0]  hh;
        logic [PpW-1:0]  hl;
        logic [PpW-1:0]  lh;
    } part_t;

    typedef struct packed {
        logic            zero;
        logic            sign;
        logic [8:0]      esum;
        logic [PpW-1:0]  sum;
    } sum_t;
endpackage
`default_nettype wire

// ===== hw/rtl/truncating_single_float_multiplier.sv =====
// Top level of the truncating single-precision multiplier.
// Four-stage pipeline; uses tsfm_pkg.
//
// channel | signals                           | direction
// in      | in_valid, in_stall, operand_a/b   | into block
// out     | out_valid, out_stall, product     | out of block
//
// One item enters per cycle while in_stall is low.
// Stages: unpack, partial products (three 13x13 / 13x11 multipliers), sum,
// normalize and pack. A stall on out holds a full stage only if every later
// stage is full; an empty stage still fills. Reset clears the valid bits only.
`default_nettype none
module truncating_single_float_multiplier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      product
);
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    tsfm_pkg::split_t s1_reg, s1_next;
    tsfm_pkg::part_t  s2_reg, s2_next;
    tsfm_pkg::sum_t   s3_reg, s3_next;
    logic [31:0]      p4_reg, p4_next;

    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall  = !en1;
    assign out_valid = v4_reg;
    assign product   = p4_reg;

    always_comb
    begin
        logic [7:0] ea, eb;
        ea = operand_a[30:23];
        eb = operand_b[30:23];
        s1_next.zero = (ea == 8'd0 && operand_a[22:0] == 23'd0)
                    || (eb == 8'd0 && operand_b[22:0] == 23'd0);
        s1_next.sign = operand_a[31] ^ operand_b[31];
        if (ea == 8'd0) ea = 8'd1;
        if (eb == 8'd0) eb = 8'd1;
        s1_next.esum = {1'b0, ea} + {1'b0, eb};
        s1_next.ha = {1'b1, operand_a[22:11]};
        s1_next.hb = {1'b1, operand_b[22:11]};
        s1_next.la = operand_a[10:0];
        s1_next.lb = operand_b[10:0];
    end

    always_comb
    begin
        s2_next.zero = s1_reg.zero;
        s2_next.sign = s1_reg.sign;
        s2_next.esum = s1_reg.esum;
        s2_next.hh = {13'd0, s1_reg.ha} * {13'd0, s1_reg.hb};
        s2_next.hl = {13'd0, s1_reg.ha} * {15'd0, s1_reg.lb};
        s2_next.lh = {15'd0, s1_reg.la} * {13'd0, s1_reg.hb};
    end

    always_comb
    begin
        s3_next.zero = s2_reg.zero;
        s3_next.sign = s2_reg.sign;
        s3_next.esum = s2_reg.esum;
        s3_next.sum = s2_reg.hh + (s2_reg.hl >> tsfm_pkg::LoW)
                    + (s2_reg.lh >> tsfm_pkg::LoW) + 26'd2;
    end

    always_comb
    begin
        logic [9:0] e;
        logic [22:0] m;
        m = s3_reg.sum[25] ? s3_reg.sum[24:2] : s3_reg.sum[23:1];
        e = {1'b0, s3_reg.esum} - tsfm_pkg::ExpBias + {9'd0, s3_reg.sum[25]};
        if (s3_reg.zero)
            p4_next = 32'd0;
        else
            p4_next = {s3_reg.sign | e[8], e[7:0], m};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (en4) p4_reg <= p4_next;
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product))
        else $error("result changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg && out_stall)
        else $error("input stalled with room in pipeline");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted item lost in stage one");
endmodule
`default_nettype wire
